/* hdl/dis_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dis_pkg
// Shared field types and fixed constants of the distinct index sampler.
// ----------------------------------------------------------------------------
package dis_pkg;

  // Fixed field widths of the ports
  localparam int RAND_W  = 31;
  localparam int SEL_W   = 10;
  localparam int CFG_W   = 11;

  // Width of the sample epoch mark kept with every slot
  localparam int EPOCH_W = 8;

  typedef logic [RAND_W-1:0]  rand_t;
  typedef logic [SEL_W-1:0]   sel_t;
  typedef logic [CFG_W-1:0]   cfg_t;
  typedef logic [EPOCH_W-1:0] epoch_t;

  // Population size after reset
  localparam cfg_t CFG_RESET = cfg_t'(1024);

  // Epoch written by the clearing pass; live samples never use it
  localparam epoch_t EPOCH_CLEAR = '0;
  localparam epoch_t EPOCH_FIRST = epoch_t'(1);
  localparam epoch_t EPOCH_LAST  = '1;

endpackage : dis_pkg
`default_nettype wire

/* hdl/dis_mod_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dis_mod_unit
// Restoring remainder unit: one dividend bit per cycle.
// ----------------------------------------------------------------------------
module dis_mod_unit #(
  parameter int DIV_W = 11
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire dis_pkg::rand_t       dividend,
  input  wire logic [DIV_W-1:0]     divisor,
  output logic                      done,
  output logic [DIV_W-1:0]          remainder
);

  localparam int CntW = $clog2(dis_pkg::RAND_W);

  logic                  busy;
  logic [CntW-1:0]       cnt;
  dis_pkg::rand_t        dvd;
  logic [DIV_W-1:0]      dsr;
  logic [DIV_W-1:0]      rem;
  logic [DIV_W:0]        trial;
  logic [DIV_W-1:0]      rem_next;

  // Shift in the next dividend bit, subtract when the partial remainder fits
  always_comb begin
    trial = {rem, dvd[dis_pkg::RAND_W-1]};
    if (trial >= {1'b0, dsr}) begin
      rem_next = DIV_W'(trial - {1'b0, dsr});
    end else begin
      rem_next = trial[DIV_W-1:0];
    end
  end

  // Control: load on start, step while busy, pulse done on the last bit
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CntW'(1);
        if (cnt == CntW'(dis_pkg::RAND_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: operand and partial remainder registers
  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dsr <= divisor;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[dis_pkg::RAND_W-2:0], 1'b0};
      rem <= rem_next;
    end
  end

  assign remainder = rem;

endmodule : dis_mod_unit
`default_nettype wire

/* hdl/dis_slot_store.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dis_slot_store
// Slot memory with one write and one read port; each word carries the epoch
// of the sample that wrote it, and a stale word reads as its own index.
// ----------------------------------------------------------------------------
module dis_slot_store #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10
) (
  input  wire logic                clk,
  input  wire dis_pkg::epoch_t     epoch,
  input  wire logic                wr_en,
  input  wire logic [ADDR_W-1:0]   wr_addr,
  input  wire logic [ADDR_W-1:0]   wr_value,
  input  wire dis_pkg::epoch_t     wr_tag,
  input  wire logic                rd_en,
  input  wire logic [ADDR_W-1:0]   rd_addr,
  output logic [ADDR_W-1:0]        rd_value
);

  localparam int WordW = dis_pkg::EPOCH_W + ADDR_W;

  logic [WordW-1:0]  mem [DEPTH];
  logic [WordW-1:0]  rd_word;
  logic [ADDR_W-1:0] rd_addr_q;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_tag, wr_value};
    end
  end

  // Read port, registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_word   <= mem[rd_addr];
      rd_addr_q <= rd_addr;
    end
  end

  // Resolve: a slot not written in this sample holds its own index
  always_comb begin
    if (rd_word[WordW-1:ADDR_W] == epoch) begin
      rd_value = rd_word[ADDR_W-1:0];
    end else begin
      rd_value = rd_addr_q;
    end
  end

endmodule : dis_slot_store
`default_nettype wire

/* hdl/distinct_index_sampler.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// distinct_index_sampler
// Partial Fisher-Yates shuffle: draws distinct indices without replacement.
// ----------------------------------------------------------------------------
//  Channel  Handshake           Payload
//  in       in_valid/in_stall   random_value, start_new
//  out      out_valid/out_stall selected_index, exhausted
//  cfg      cfg_we              cfg_wdata (population_size)
//
//  A draw runs the bit-serial remainder unit, reads the two slots and
//  makes two write-backs through the single-write-port slot memory.
//  After reset a clearing pass marks all MAX_POPULATION slots stale; the
//  same pass reruns on the start of every 255th sample, when the epoch
//  mark wraps. The input stays stalled during the pass.
//  A result waits in the output register while the next item is taken.
// ----------------------------------------------------------------------------
module distinct_index_sampler #(
  parameter int MAX_POPULATION = 1024
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire dis_pkg::rand_t   random_value,
  input  wire logic             start_new,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output dis_pkg::sel_t         selected_index,
  output logic                  exhausted,
  input  wire logic             cfg_we,
  input  wire dis_pkg::cfg_t    cfg_wdata
);

  localparam int IdxW = $clog2(MAX_POPULATION);
  localparam int CntW = $clog2(MAX_POPULATION + 1);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_RDP   = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_RDR   = 3'd5;
  localparam logic [2:0] S_WR    = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0]            state;
  dis_pkg::cfg_t         population_size;
  dis_pkg::epoch_t       epoch;
  logic [IdxW-1:0]       pos;
  logic [IdxW-1:0]       clr_cnt;
  logic                  clr_resume;
  dis_pkg::rand_t        rand_q;
  logic                  exh_q;
  logic [IdxW-1:0]       vp;
  logic [IdxW-1:0]       vr;
  logic [IdxW-1:0]       r_addr;

  logic                  in_xfer;
  logic                  out_free;
  logic [CntW-1:0]       size_eff;
  logic                  no_draw;
  logic                  div_start;
  logic                  div_done;
  logic [CntW-1:0]       div_rem;
  logic [IdxW-1:0]       r_calc;

  logic                  wr_en;
  logic [IdxW-1:0]       wr_addr;
  logic [IdxW-1:0]       wr_value;
  dis_pkg::epoch_t       wr_tag;
  logic                  rd_en;
  logic [IdxW-1:0]       rd_addr;
  logic [IdxW-1:0]       rd_value;

  assign in_stall = rst || (state != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // Saturate the population size to the store depth
  always_comb begin
    if (32'(population_size) > MAX_POPULATION) begin
      size_eff = CntW'(MAX_POPULATION);
    end else begin
      size_eff = CntW'(population_size);
    end
  end

  assign no_draw   = (size_eff < CntW'(2)) || ((CntW'(pos) + CntW'(1)) >= size_eff);
  assign div_start = (state == S_CHECK) && !no_draw;
  assign r_calc    = IdxW'(div_rem) + pos;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      population_size <= dis_pkg::CFG_RESET;
    end else if (cfg_we) begin
      population_size <= cfg_wdata;
    end
  end

  // Slot memory access per state
  always_comb begin
    wr_en    = 1'b0;
    wr_addr  = pos;
    wr_value = '0;
    wr_tag   = epoch;
    rd_en    = 1'b0;
    rd_addr  = pos;
    unique case (state)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_cnt;
        wr_tag  = dis_pkg::EPOCH_CLEAR;
      end
      S_CHECK: begin
        rd_en = !no_draw;
      end
      S_DIV: begin
        rd_en   = div_done;
        rd_addr = r_calc;
      end
      S_RDR: begin
        wr_en    = 1'b1;
        wr_value = rd_value;
      end
      S_WR: begin
        wr_en    = 1'b1;
        wr_addr  = r_addr;
        wr_value = vp;
      end
      default: begin
      end
    endcase
  end

  // Sequencer: clear, take an item, read, divide, swap, deliver
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_cnt    <= '0;
      clr_resume <= 1'b0;
      epoch      <= dis_pkg::EPOCH_CLEAR;
      pos        <= '0;
      out_valid  <= 1'b0;
    end else begin
      // Raise on a new result, drop after its transfer
      if ((state == S_OUT) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          if (clr_cnt == IdxW'(MAX_POPULATION - 1)) begin
            clr_cnt <= '0;
            epoch   <= dis_pkg::EPOCH_FIRST;
            state   <= clr_resume ? S_CHECK : S_IDLE;
          end else begin
            clr_cnt <= clr_cnt + IdxW'(1);
          end
        end
        S_IDLE: begin
          if (in_xfer) begin
            if (start_new && (epoch == dis_pkg::EPOCH_LAST)) begin
              clr_resume <= 1'b1;
              state      <= S_CLEAR;
            end else begin
              clr_resume <= 1'b0;
              state      <= S_CHECK;
            end
            if (start_new) begin
              pos <= '0;
              if (epoch != dis_pkg::EPOCH_LAST) begin
                epoch <= epoch + dis_pkg::epoch_t'(1);
              end
            end
          end
        end
        S_CHECK: begin
          state <= no_draw ? S_OUT : S_RDP;
        end
        S_RDP: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_RDR;
          end
        end
        S_RDR: begin
          state <= S_WR;
        end
        S_WR: begin
          pos   <= pos + IdxW'(1);
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Item payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      rand_q <= random_value;
    end
    if (state == S_CHECK) begin
      exh_q <= no_draw;
    end
    if (state == S_RDP) begin
      vp <= rd_value;
    end
    if ((state == S_DIV) && div_done) begin
      r_addr <= r_calc;
    end
    if (state == S_RDR) begin
      vr <= rd_value;
    end
    if ((state == S_OUT) && out_free) begin
      exhausted      <= exh_q;
      selected_index <= exh_q ? '0 : dis_pkg::sel_t'(vr);
    end
  end

  dis_mod_unit #(
    .DIV_W (CntW)
  ) u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (rand_q),
    .divisor   (size_eff - CntW'(pos)),
    .done      (div_done),
    .remainder (div_rem)
  );

  dis_slot_store #(
    .DEPTH  (MAX_POPULATION),
    .ADDR_W (IdxW)
  ) u_store (
    .clk      (clk),
    .epoch    (epoch),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_value (wr_value),
    .wr_tag   (wr_tag),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_value (rd_value)
  );

  // A live sample never runs with the epoch the clearing pass writes
  a_epoch_live: assert property (@(posedge clk) disable iff (rst)
    (state != S_CLEAR) |-> (epoch != dis_pkg::EPOCH_CLEAR))
    else $error("live epoch equals clear mark");

  // The remainder unit only finishes while the sequencer waits for it
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV))
    else $error("remainder done outside divide state");

  // The swap partner never lies below the draw position
  a_swap_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_RDR) |-> (r_addr >= pos))
    else $error("swap slot below draw position");

endmodule : distinct_index_sampler
`default_nettype wire

/* dv/tb_distinct_index_sampler.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_distinct_index_sampler
// Self-checking bench for the distinct index sampler. A queue-fed driver
// offers draw requests, and a shuffle-table model inside the bench predicts
// each pick. A monitor compares every returned transfer against the oldest
// prediction. Phases sweep the population size and the idle and stall rates
// on both channels, and one phase stalls the output long enough to back up
// the input.
// ----------------------------------------------------------------------------
module tb_distinct_index_sampler;

  localparam int MAX_POP      = 1024;
  localparam int IDX_W        = $clog2(MAX_POP);
  localparam int LIMIT_CYCLES = 600000;
  localparam int ITEM_TARGET  = 1450;
  localparam int SETTLE       = 40;
  localparam int HOLDOFF      = 400;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  typedef struct {
    dis_pkg::rand_t rv;
    logic           st;
  } draw_req_t;

  typedef struct {
    dis_pkg::sel_t idx;
    logic          exh;
  } pick_t;

  logic           clk;
  logic           rst;
  logic           in_valid;
  logic           in_stall;
  dis_pkg::rand_t random_value;
  logic           start_new;
  logic           out_valid;
  logic           out_stall;
  dis_pkg::sel_t  selected_index;
  logic           exhausted;
  logic           cfg_we;
  dis_pkg::cfg_t  cfg_wdata;

  draw_req_t request_q[$];
  pick_t     expected_picks[$];

  // Bench copy of the shuffle table and the draw state
  dis_pkg::sel_t      shuffle_tab[MAX_POP];
  logic [MAX_POP-1:0] tab_touched = '0;
  dis_pkg::cfg_t      draw_pos = '0;
  dis_pkg::cfg_t      pop_size = dis_pkg::CFG_RESET;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_go = 1'b0;
  bit rx_hold;
  int errors = 0;
  int cycles = 0;
  int queued = 0;

  distinct_index_sampler #(
    .MAX_POPULATION(MAX_POP)
  ) u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .random_value   (random_value),
    .start_new      (start_new),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .selected_index (selected_index),
    .exhausted      (exhausted),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Predict one draw and queue the pick it must return
  function automatic void draw_index(dis_pkg::rand_t rv, logic st);
    int unsigned      size;
    int unsigned      pos;
    int unsigned      r;
    logic [IDX_W-1:0] pi;
    logic [IDX_W-1:0] ri;
    dis_pkg::sel_t    at_pos;
    dis_pkg::sel_t    at_r;
    pick_t            res;
    size = (32'(pop_size) > MAX_POP) ? 32'(MAX_POP) : 32'(pop_size);
    if (st) begin
      tab_touched = '0;
      draw_pos = '0;
    end
    pos = 32'(draw_pos);
    if (size < 2 || pos + 1 >= size) begin
      res.idx = '0;
      res.exh = 1'b1;
    end else begin
      r = 32'(rv) % (size - pos) + pos;
      pi = IDX_W'(pos);
      ri = IDX_W'(r);
      at_pos = tab_touched[pi] ? shuffle_tab[pi] : dis_pkg::sel_t'(pos);
      at_r = tab_touched[ri] ? shuffle_tab[ri] : dis_pkg::sel_t'(r);
      shuffle_tab[pi] = at_r;
      tab_touched[pi] = 1'b1;
      shuffle_tab[ri] = at_pos;
      tab_touched[ri] = 1'b1;
      draw_pos = draw_pos + dis_pkg::cfg_t'(1);
      res.idx = at_r;
      res.exh = 1'b0;
    end
    expected_picks.push_back(res);
  endfunction

  function automatic dis_pkg::rand_t rand_word();
    case ($urandom_range(15))
      0: return '0;
      1: return '1;
      default: return dis_pkg::rand_t'($urandom);
    endcase
  endfunction

  task automatic queue_item(dis_pkg::rand_t rv, logic st);
    draw_req_t req;
    req.rv = rv;
    req.st = st;
    request_q.push_back(req);
    queued++;
  endtask

  // Queue a run of draws, optionally opening a new sample
  task automatic queue_sample(int n, bit fresh);
    for (int i = 0; i < n; i++) begin
      queue_item(rand_word(), fresh && i == 0);
    end
  endtask

  task automatic set_idle(idle_mode_e mode);
    @(negedge clk);
    case (mode)
      IDLE_NONE: begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      IDLE_SEND: begin
        send_idle_pct = 58;
        recv_stall_pct = 0;
      end
      IDLE_RECV: begin
        send_idle_pct = 0;
        recv_stall_pct = 58;
      end
      default: begin
        send_idle_pct = 19;
        recv_stall_pct = 19;
      end
    endcase
  endtask

  // Wait until every queued draw has gone out and every pick has come back
  task automatic drain();
    @(negedge clk);
    while (request_q.size() != 0 || in_valid || expected_picks.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_size(dis_pkg::cfg_t v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    pop_size = v;
  endtask

  // Offer queued draws; predict each one as its transfer completes
  always @(posedge clk) begin : driver
    draw_req_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
      random_value <= '0;
      start_new <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        draw_index(random_value, start_new);
      end
      if (!in_valid || !in_stall) begin
        if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = request_q.pop_front();
          in_valid <= 1'b1;
          random_value <= nxt.rv;
          start_new <= nxt.st;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Check each result transfer against the oldest prediction
  always @(posedge clk) begin : monitor
    pick_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_picks.size() == 0) begin
          $error("unexpected result: selected_index %0d exhausted %0b",
                 selected_index, exhausted);
          errors++;
        end else begin
          want = expected_picks.pop_front();
          if (selected_index !== want.idx) begin
            $error("selected_index: expected %0d, actual %0d", want.idx, selected_index);
            errors++;
          end
          if (exhausted !== want.exh) begin
            $error("exhausted: expected %0b, actual %0b", want.exh, exhausted);
            errors++;
          end
        end
      end
      out_stall <= rx_hold || ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Hold off the output for a long stretch once the pressure phase begins
  initial begin : rx_holdoff
    rx_hold = 1'b0;
    wait (hold_go);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLDOFF) @(posedge clk);
    rx_hold <= 1'b0;
  end

  // Abort a run that stops making progress
  always @(posedge clk) begin : watchdog
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    int         phase;
    int         size;
    int         eff;
    int         budget;
    int         n;
    int         k;
    bit         first;
    idle_mode_e mode;
    in_valid = 1'b0;
    random_value = '0;
    start_new = 1'b0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    rst = 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Reset size, extreme random words
    @(negedge clk);
    queue_item('0, 1'b1);
    queue_item('1, 1'b0);
    queue_item(dis_pkg::rand_t'(12345), 1'b0);
    drain();
    // Size above the store saturates
    write_size(dis_pkg::cfg_t'(2047));
    @(negedge clk);
    queue_item('1, 1'b1);
    queue_item('0, 1'b0);
    drain();
    // Sizes below two always answer exhausted
    write_size(dis_pkg::cfg_t'(0));
    @(negedge clk);
    queue_item(rand_word(), 1'b0);
    queue_item('1, 1'b1);
    drain();
    write_size(dis_pkg::cfg_t'(1));
    @(negedge clk);
    queue_item('0, 1'b1);
    drain();
    // Exhaust, then start again on an exhausted sample
    write_size(dis_pkg::cfg_t'(2));
    @(negedge clk);
    queue_item(dis_pkg::rand_t'(5), 1'b1);
    queue_item('1, 1'b0);
    queue_item('0, 1'b1);
    drain();
    write_size(dis_pkg::cfg_t'(3));
    @(negedge clk);
    queue_item('1, 1'b1);
    queue_item(dis_pkg::rand_t'(7), 1'b0);
    queue_item(dis_pkg::rand_t'(9), 1'b0);
    drain();
    // Grow the size mid-sample; table and position carry over
    write_size(dis_pkg::cfg_t'(5));
    @(negedge clk);
    queue_item('1, 1'b0);
    queue_item('0, 1'b0);
    queue_item(dis_pkg::rand_t'(3), 1'b0);
    drain();

    // Back up the input behind a long output hold, then pause the sender
    write_size(dis_pkg::cfg_t'(40));
    set_idle(IDLE_NONE);
    hold_go = 1'b1;
    for (int i = 0; i < 3; i++) begin
      queue_sample(20, 1'b1);
    end
    drain();
    @(negedge clk);
    for (int i = 0; i < 3; i++) begin
      queue_sample(20, 1'b1);
    end
    drain();

    // Random phases over sizes and idle rates
    phase = 0;
    while (queued < ITEM_TARGET) begin
      mode = idle_mode_e'(phase % 4);
      k = $urandom_range(99);
      if (k < 8) begin
        size = $urandom_range(1, 0);
      end else if (k < 14) begin
        size = MAX_POP;
      end else if (k < 20) begin
        size = $urandom_range(2047, MAX_POP + 1);
      end else if (k < 30) begin
        size = $urandom_range(300, 41);
      end else begin
        size = $urandom_range(40, 2);
      end
      eff = (size > MAX_POP) ? MAX_POP : size;
      write_size(dis_pkg::cfg_t'(size));
      set_idle(mode);
      first = 1'b1;
      budget = 90;
      while (budget > 0) begin
        if ($urandom_range(99) < 85) begin
          n = $urandom_range((eff + 2 < 60) ? eff + 2 : 60, 1);
          // The first run of a phase may continue the previous sample
          queue_sample(n, first ? 1'($urandom_range(1, 0)) : 1'b1);
        end else begin
          n = $urandom_range(8, 1);
          for (int i = 0; i < n; i++) begin
            queue_item(rand_word(), $urandom_range(2) == 0);
          end
        end
        first = 1'b0;
        budget -= n;
      end
      drain();
      phase++;
    end

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/dis_pkg.sv
hdl/dis_mod_unit.sv
hdl/dis_slot_store.sv
hdl/distinct_index_sampler.sv
dv/tb_distinct_index_sampler.sv
